// File: src/sepg_pkg.sv
// Shared types, constants and field layout for the sequential ESC pulse generator.
`default_nettype none

package sepg_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int COUNT_WIDTH = 16;
    localparam int MOTOR_IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    localparam int US_W    = 12;
    localparam int TPU_W   = 7;
    localparam int OP_W    = 2;
    localparam int IDX_W   = 2;
    localparam int PINS_W  = 4;
    localparam int PROD_W  = US_W + TPU_W;

    localparam int S_DATA_W = 16;   // motor_index + pulse_us, padded to bytes
    localparam int M_DATA_W = 8;    // motor_pins + max_warning + switched, padded
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [US_W-1:0]  MIN_US_RST = US_W'(1000);
    localparam logic [US_W-1:0]  MAX_US_RST = US_W'(2000);
    localparam logic [TPU_W-1:0] TPU_RST    = TPU_W'(16);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam longint WIDTH_RST_FULL = longint'(1000) * longint'(16);
    localparam logic [COUNT_WIDTH-1:0] WIDTH_RST =
        (WIDTH_RST_FULL > longint'(CNT_MAX)) ? CNT_MAX : COUNT_WIDTH'(WIDTH_RST_FULL);

    // register indexes (word address bits)
    localparam logic [1:0] REG_MIN_US = 2'd0;
    localparam logic [1:0] REG_MAX_US = 2'd1;
    localparam logic [1:0] REG_TPU    = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_SPEED = 2'd1,
        OP_IDLE  = 2'd2
    } t_op;

    typedef logic [COUNT_WIDTH-1:0] t_ticks;

    typedef struct packed {
        logic [US_W-1:0]  min_us;
        logic [US_W-1:0]  max_us;
        logic [TPU_W-1:0] tpu;
    } t_cfg;

endpackage

`default_nettype wire

// File: src/sepg_width_conv.sv
// Clamp a requested width to the min/max window and convert it to saturated ticks.
`default_nettype none

module sepg_width_conv (
    input  wire sepg_pkg::t_cfg               i_cfg,
    input  wire logic [sepg_pkg::US_W-1:0]    i_req_us,
    input  wire logic                         i_use_min,
    output sepg_pkg::t_ticks                  o_ticks,
    output logic                              o_warn
);
    import sepg_pkg::*;

    logic [US_W-1:0]   us_sel;
    logic [PROD_W-1:0] prod;

    // minimum test first, so with min above max a request below the minimum still yields the minimum
    always_comb begin
        o_warn = 1'b0;
        if (i_use_min || (i_req_us < i_cfg.min_us)) begin
            us_sel = i_cfg.min_us;
        end else if (i_req_us > i_cfg.max_us) begin
            us_sel = i_cfg.max_us;
            o_warn = 1'b1;
        end else begin
            us_sel = i_req_us;
        end
    end

    assign prod = PROD_W'(us_sel) * PROD_W'(i_cfg.tpu);

    always_comb begin
        if (PROD_W > COUNT_WIDTH) begin
            o_ticks = (prod > PROD_W'(CNT_MAX)) ? CNT_MAX : COUNT_WIDTH'(prod);
        end else begin
            o_ticks = COUNT_WIDTH'(prod);
        end
    end

endmodule

`default_nettype wire

// File: src/sequential_esc_pulse_generator.sv
// Top level: four ESC pulse pins driven in turn from one tick counter.
`default_nettype none

// Channel    | Dir | Handshake              | Payload
// -----------+-----+------------------------+---------------------------------------
// stream in  | in  | i_s_tvalid/o_s_tready  | tuser: operation; tdata: index, pulse_us
// stream out | out | o_m_tvalid/i_m_tready  | tdata: motor_pins, max_warning, switched
// config     | in  | i_psel/i_penable/APB   | min_pulse_us, max_pulse_us, ticks_per_us
//
// One result transfer per input transfer; a new item is taken every cycle
// unless stalled. Path: input register, then one pass of clamp, multiply
// and counter compare into the result register. The 12x7 multiply sets
// the cycle. A stalled output holds the result and back-pressures via the
// input register only once both are full. Synchronous reset restores the
// default registers, loads every width and the compare with 1000 us x 16.

module sequential_esc_pulse_generator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // stream in
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [sepg_pkg::S_DATA_W-1:0]     i_s_tdata,  // [1:0] motor_index, [13:2] pulse_us
    input  wire logic [sepg_pkg::OP_W-1:0]         i_s_tuser,  // [1:0] operation
    // stream out
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [sepg_pkg::M_DATA_W-1:0]          o_m_tdata,  // [3:0] motor_pins, [4] max_warning,
                                                               // [5] switched
    // APB config
    input  wire logic                              i_psel,
    input  wire logic                              i_penable,
    input  wire logic                              i_pwrite,
    input  wire logic [sepg_pkg::APB_AW-1:0]       i_paddr,
    input  wire logic [sepg_pkg::APB_DW-1:0]       i_pwdata,
    output logic [sepg_pkg::APB_DW-1:0]            o_prdata,
    output logic                                   o_pready
);
    import sepg_pkg::*;

    // ---------------- configuration registers ----------------
    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [1:0] cfg_sel;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign cfg_sel  = i_paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_us <= MIN_US_RST;
            r_cfg.max_us <= MAX_US_RST;
            r_cfg.tpu    <= TPU_RST;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_MIN_US: r_cfg.min_us <= i_pwdata[US_W-1:0];
                REG_MAX_US: r_cfg.max_us <= i_pwdata[US_W-1:0];
                REG_TPU:    r_cfg.tpu    <= i_pwdata[TPU_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_MIN_US: o_prdata = APB_DW'(r_cfg.min_us);
            REG_MAX_US: o_prdata = APB_DW'(r_cfg.max_us);
            REG_TPU:    o_prdata = APB_DW'(r_cfg.tpu);
            default:    o_prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    logic             r_in_valid;
    logic [OP_W-1:0]  r_op;
    logic [IDX_W-1:0] r_idx;
    logic [US_W-1:0]  r_req_us;
    logic             advance;

    // item in the input register moves on when the result slot is free or draining
    assign advance    = r_in_valid && (!o_m_tvalid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_op     <= i_s_tuser;
            r_idx    <= i_s_tdata[IDX_W-1:0];
            r_req_us <= i_s_tdata[IDX_W +: US_W];
        end
    end

    // ---------------- pulse state ----------------
    t_ticks                  r_width [MOTOR_COUNT];
    t_ticks                  r_count;
    t_ticks                  r_compare;
    logic [MOTOR_IDX_W-1:0]  r_active;
    logic                    r_started;
    logic [MOTOR_COUNT-1:0]  r_pins;

    t_ticks                  n_count;
    t_ticks                  n_compare;
    logic [MOTOR_IDX_W-1:0]  n_active;
    logic                    n_started;
    logic [MOTOR_COUNT-1:0]  n_pins;
    logic                    n_warn;
    logic                    n_switched;
    logic                    wr_one;
    logic                    wr_all;
    logic [MOTOR_IDX_W-1:0]  wr_idx;

    t_ticks                  conv_ticks;
    logic                    conv_warn;
    t_ticks                  cnt_inc;
    logic [MOTOR_IDX_W-1:0]  base_motor;
    logic [MOTOR_IDX_W-1:0]  next_motor;

    sepg_width_conv u_conv (
        .i_cfg     (r_cfg),
        .i_req_us  (r_req_us),
        .i_use_min (t_op'(r_op) == OP_IDLE),
        .o_ticks   (conv_ticks),
        .o_warn    (conv_warn)
    );

    assign cnt_inc    = r_count + COUNT_WIDTH'(1);
    // first match parks on motor 0 and switches straight on to motor 1
    assign base_motor = r_started ? r_active : '0;
    assign next_motor = (base_motor == MOTOR_IDX_W'(MOTOR_COUNT - 1))
                        ? '0 : base_motor + MOTOR_IDX_W'(1);
    assign wr_idx     = MOTOR_IDX_W'(r_idx);

    always_comb begin
        n_count    = r_count;
        n_compare  = r_compare;
        n_active   = r_active;
        n_started  = r_started;
        n_pins     = r_pins;
        n_warn     = 1'b0;
        n_switched = 1'b0;
        wr_one     = 1'b0;
        wr_all     = 1'b0;
        case (t_op'(r_op))
            OP_TICK: begin
                n_count = cnt_inc;
                if (cnt_inc == r_compare) begin
                    n_started  = 1'b1;
                    n_active   = next_motor;
                    n_pins     = MOTOR_COUNT'(1) << next_motor;
                    n_compare  = r_width[next_motor];
                    n_count    = '0;
                    n_switched = 1'b1;
                end
            end
            OP_SPEED: begin
                if (32'(r_idx) < MOTOR_COUNT) begin
                    wr_one = 1'b1;
                    n_warn = conv_warn;
                end
            end
            OP_IDLE: begin
                wr_all = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                r_width[k] <= WIDTH_RST;
            end
            r_count   <= '0;
            r_compare <= WIDTH_RST;
            r_active  <= '0;
            r_started <= 1'b0;
            r_pins    <= '0;
        end else if (advance) begin
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                if (wr_all || (wr_one && (wr_idx == MOTOR_IDX_W'(k)))) begin
                    r_width[k] <= conv_ticks;
                end
            end
            r_count   <= n_count;
            r_compare <= n_compare;
            r_active  <= n_active;
            r_started <= n_started;
            r_pins    <= n_pins;
        end
    end

    // ---------------- result register ----------------
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= M_DATA_W'({n_switched, n_warn, PINS_W'(n_pins)});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// File: sim/tb_sequential_esc_pulse_generator.sv
// Self-checking testbench for the sequential ESC pulse generator: stream, APB and pulse timing.

module tb_sequential_esc_pulse_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import sepg_pkg::*;

    // Spare operation code: the block must leave all state alone and report the pins.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // Bounds on the run. The long tick runs (first match after reset, counter wrap)
    // dominate; the cap is several times the slowest legal run.
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int RANDOM_ITEMS = 100;    // per random phase
    localparam int CHOKE_CYCLES = 400;    // long receiver hold-off

    // One result transfer: the fields of o_m_tdata, though not in its bit order.
    typedef struct packed {
        logic [PINS_W-1:0] pins;
        logic              warn;
        logic              sw;
    } t_pulse_out;

    // Directed stimulus rows.
    typedef enum logic [1:0] {
        ROW_ITEM,   // one input transfer
        ROW_RUN,    // ticks until the pulse train switches motor
        ROW_CFG     // drain, then load the three registers
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [OP_W-1:0]    op;
        logic [IDX_W-1:0]   idx;
        logic [US_W-1:0]    us;
        logic               hand;   // typed-in expectation in res, else the predictor's
        t_pulse_out         res;
        t_cfg               cfg;
    } t_dir_row;

    localparam t_pulse_out QUIET  = '{4'h0, 1'b0, 1'b0};
    localparam t_pulse_out WARNED = '{4'h0, 1'b1, 1'b0};
    localparam t_cfg       NO_CFG = '0;

    // Rows up to the first CFG run with reset settings and no pulse yet, so the
    // pins are all low and only the clamp warning moves.
    localparam t_dir_row DIR_TABLE [0:24] = '{
        '{ROW_ITEM, OP_TICK,  2'd0, 12'd0,    1'b1, QUIET,  NO_CFG},
        '{ROW_ITEM, OP_SPEED, 2'd0, 12'd4095, 1'b1, WARNED, NO_CFG},  // far above max
        '{ROW_ITEM, OP_SPEED, 2'd1, 12'd0,    1'b1, QUIET,  NO_CFG},  // below min
        '{ROW_ITEM, OP_SPEED, 2'd2, 12'd2000, 1'b1, QUIET,  NO_CFG},  // exactly max
        '{ROW_ITEM, OP_SPEED, 2'd3, 12'd2001, 1'b1, WARNED, NO_CFG},  // just above max
        '{ROW_ITEM, OP_SPEED, 2'd3, 12'd1000, 1'b1, QUIET,  NO_CFG},  // exactly min
        '{ROW_ITEM, OP_IDLE,  2'd0, 12'd0,    1'b1, QUIET,  NO_CFG},
        '{ROW_ITEM, OP_SPARE, 2'd3, 12'd4095, 1'b1, QUIET,  NO_CFG},
        '{ROW_ITEM, OP_TICK,  2'd3, 12'd4095, 1'b1, QUIET,  NO_CFG},
        '{ROW_CFG,  OP_TICK,  2'd0, 12'd0,    1'b0, QUIET,  '{12'd2, 12'd6, 7'd1}},
        '{ROW_ITEM, OP_IDLE,  2'd0, 12'd0,    1'b1, QUIET,  NO_CFG},
        '{ROW_ITEM, OP_SPEED, 2'd1, 12'd1,    1'b1, QUIET,  NO_CFG},
        '{ROW_ITEM, OP_SPEED, 2'd2, 12'd9,    1'b1, WARNED, NO_CFG},
        '{ROW_ITEM, OP_SPEED, 2'd3, 12'd4,    1'b1, QUIET,  NO_CFG},
        '{ROW_ITEM, OP_SPEED, 2'd0, 12'd6,    1'b1, QUIET,  NO_CFG},
        // first match: still loaded with the reset compare, motor 1 rises first
        '{ROW_RUN,  OP_TICK,  2'd0, 12'd0,    1'b0, QUIET,  NO_CFG},
        '{ROW_ITEM, OP_TICK,  2'd0, 12'd0,    1'b0, QUIET,  NO_CFG},
        '{ROW_ITEM, OP_TICK,  2'd0, 12'd0,    1'b0, QUIET,  NO_CFG},
        '{ROW_RUN,  OP_TICK,  2'd0, 12'd0,    1'b0, QUIET,  NO_CFG},
        '{ROW_RUN,  OP_TICK,  2'd0, 12'd0,    1'b0, QUIET,  NO_CFG},  // switches to motor 0
        '{ROW_RUN,  OP_TICK,  2'd0, 12'd0,    1'b0, QUIET,  NO_CFG},
        // minimum above maximum, scale of 64
        '{ROW_CFG,  OP_TICK,  2'd0, 12'd0,    1'b0, QUIET,  '{12'd4095, 12'd0, 7'd64}},
        '{ROW_ITEM, OP_SPEED, 2'd0, 12'd100,  1'b0, QUIET,  NO_CFG},
        '{ROW_ITEM, OP_SPEED, 2'd1, 12'd4095, 1'b0, QUIET,  NO_CFG},
        '{ROW_ITEM, OP_SPARE, 2'd2, 12'd77,   1'b0, QUIET,  NO_CFG}
    };

    // Settings for the random phases; a zero scale means draw small settings at
    // random. Wide-width phases sit last so the compare they leave behind costs
    // little. The final phase keeps the minimum at full scale.
    localparam t_cfg PHASE_CFG [0:7] = '{
        '{12'd2,    12'd6,    7'd1},
        '{12'd1,    12'd3,    7'd3},
        '{12'd3,    12'd3,    7'd2},
        '{12'd0,    12'd0,    7'd0},
        '{12'd0,    12'd0,    7'd0},
        '{12'd5,    12'd20,   7'd1},
        '{12'd1,    12'd4095, 7'd64},
        '{12'd4095, 12'd0,    7'd1}
    };

    // DUT ports
    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata;   // [1:0] motor_index, [13:2] pulse_us, [15:14] zero
    logic [OP_W-1:0]     i_s_tuser;   // [1:0] operation
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [M_DATA_W-1:0] o_m_tdata;   // [3:0] motor_pins, [4] max_warning, [5] switched
    logic                i_psel;
    logic                i_penable;
    logic                i_pwrite;
    logic [APB_AW-1:0]   i_paddr;
    logic [APB_DW-1:0]   i_pwdata;
    logic [APB_DW-1:0]   o_prdata;
    logic                o_pready;

    sequential_esc_pulse_generator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    // Shadow of the block: settings, stored widths and the pulse train.
    t_cfg              shadow_cfg;
    t_ticks            shadow_width [MOTOR_COUNT];
    t_ticks            shadow_count;
    t_ticks            shadow_compare;
    logic [IDX_W-1:0]  shadow_active;
    logic              shadow_started;
    logic [PINS_W-1:0] shadow_pins;

    t_pulse_out awaited_pulses [$];   // results owed by the block, oldest first
    int         faults;
    int         cycle_count;
    int         burst_left;           // sender transfers left in the current burst
    bit         gaps_on;              // sender idles between bursts
    int         hold_asks;            // long receiver hold-offs requested so far

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Runaway guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_sequential_esc_pulse_generator failed");
            $finish;
        end
    end

    // us -> ticks, a plain multiply saturated to the counter width
    function automatic t_ticks scale_to_ticks(logic [US_W-1:0] us);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(us) * PROD_W'(shadow_cfg.tpu);
        return (prod > PROD_W'(CNT_MAX)) ? CNT_MAX : t_ticks'(prod);
    endfunction

    // Apply one accepted item to the shadow and return the result it owes.
    function automatic t_pulse_out advance_pulse_train(logic [OP_W-1:0] op,
                                                       logic [IDX_W-1:0] idx,
                                                       logic [US_W-1:0] us);
        t_pulse_out       r;
        logic [IDX_W-1:0] nxt;
        r = '0;
        case (op)
            OP_TICK: begin
                shadow_count = shadow_count + 1'b1;   // wraps at 2^16
                if (shadow_count == shadow_compare) begin
                    // first match: motor 0 is taken as active, so motor 1 rises
                    if (!shadow_started) begin
                        shadow_started = 1'b1;
                        shadow_active  = '0;
                    end
                    nxt            = shadow_active + 1'b1;   // four motors: 2-bit wrap
                    shadow_pins    = PINS_W'(1) << nxt;
                    shadow_compare = shadow_width[nxt];
                    shadow_active  = nxt;
                    shadow_count   = '0;
                    r.sw           = 1'b1;
                end
            end
            OP_SPEED: begin
                // minimum test first, so with min > max a request below the minimum still gets the minimum
                if (us < shadow_cfg.min_us) begin
                    shadow_width[idx] = scale_to_ticks(shadow_cfg.min_us);
                end else if (us > shadow_cfg.max_us) begin
                    shadow_width[idx] = scale_to_ticks(shadow_cfg.max_us);
                    r.warn = 1'b1;
                end else begin
                    shadow_width[idx] = scale_to_ticks(us);
                end
            end
            OP_IDLE: begin
                for (int k = 0; k < MOTOR_COUNT; k++)
                    shadow_width[k] = scale_to_ticks(shadow_cfg.min_us);
            end
            default: ;
        endcase
        r.pins = shadow_pins;
        return r;
    endfunction

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            faults++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endfunction

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_access(input bit wr, input logic [1:0] reg_idx,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= wr;
        i_paddr   <= {reg_idx, 2'b00};
        i_pwdata  <= wdata;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        rdata = o_prdata;
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
    endtask

    // Park the sender and wait until every owed result has been transferred.
    task automatic drain_results();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (awaited_pulses.size() != 0) @(posedge i_clk);
    endtask

    // Registers only change with the block idle; read each one back.
    task automatic load_settings(input t_cfg c);
        logic [APB_DW-1:0] rd;
        drain_results();
        apb_access(1'b1, REG_MIN_US, APB_DW'(c.min_us), rd);
        apb_access(1'b1, REG_MAX_US, APB_DW'(c.max_us), rd);
        apb_access(1'b1, REG_TPU,    APB_DW'(c.tpu),    rd);
        shadow_cfg = c;
        apb_access(1'b0, REG_MIN_US, '0, rd);
        check_field("min_pulse_us readback", c.min_us, rd[US_W-1:0]);
        apb_access(1'b0, REG_MAX_US, '0, rd);
        check_field("max_pulse_us readback", c.max_us, rd[US_W-1:0]);
        apb_access(1'b0, REG_TPU, '0, rd);
        check_field("ticks_per_us readback", c.tpu, rd[TPU_W-1:0]);
    endtask

    // Offer one item in the current burst; predict it on acceptance.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [US_W-1:0] us, input bit hand,
                             input t_pulse_out hand_res, output t_pulse_out got);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                gap = $urandom_range(1, 5);
                repeat (gap) begin
                    @(negedge i_clk);
                    i_s_tvalid <= 1'b0;
                end
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {2'b00, us, idx};
        do @(posedge i_clk); while (!o_s_tready);
        got = advance_pulse_train(op, idx, us);
        // typed-in rows still advance the shadow, but the hand value is what is owed
        awaited_pulses.push_back(hand ? hand_res : got);
    endtask

    // Ticks with noise in the unused fields until the train switches motor.
    task automatic run_to_switch();
        t_pulse_out res;
        do begin
            send_item(OP_TICK, IDX_W'($urandom), US_W'($urandom), 1'b0, '0, res);
        end while (!res.sw);
    endtask

    function automatic logic [US_W-1:0] near_us(logic [US_W-1:0] base);
        int v;
        v = int'(base) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return US_W'(v);
    endfunction

    // Result checker: every output transfer against the oldest owed result.
    t_pulse_out owed;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (awaited_pulses.size() == 0) begin
                faults++;
                $display("%0t: result with nothing owed, expected none, got tdata 0x%0h",
                         $time, o_m_tdata);
            end else begin
                owed = awaited_pulses.pop_front();
                check_field("motor_pins",  owed.pins, o_m_tdata[3:0]);
                check_field("max_warning", owed.warn, o_m_tdata[4]);
                check_field("switched",    owed.sw,   o_m_tdata[5]);
            end
        end
    end

    // Receiver: its own stall pattern, cycling through four modes in turn, plus long
    // hold-offs on request so the block fills and stalls its input.
    initial begin
        int unsigned rx_tick;
        int unsigned hold_left;
        int          holds_served;
        bit          rdy;
        rx_tick      = 0;
        hold_left    = 0;
        holds_served = 0;
        i_m_tready   = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_tick++;
            if (hold_left == 0 && holds_served != hold_asks) begin
                holds_served++;
                hold_left = CHOKE_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case ((rx_tick / 97) % 4)
                    0:       rdy = 1'b1;                           // no stalls
                    1:       rdy = ($urandom_range(0, 3) != 0);
                    2:       rdy = (rx_tick % 3 == 0);
                    default: rdy = ($urandom_range(0, 9) < 4);
                endcase
            end
            i_m_tready <= rdy;
        end
    end

    // Main sequence
    initial begin
        t_dir_row   row;
        t_cfg       c;
        t_pulse_out res;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        logic [US_W-1:0]  us;
        int         r;
        int         k;

        faults      = 0;
        cycle_count = 0;
        burst_left  = 0;
        gaps_on     = 1'b1;
        hold_asks   = 0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_psel      = 1'b0;
        i_penable   = 1'b0;
        i_pwrite    = 1'b0;
        i_paddr     = '0;
        i_pwdata    = '0;

        // shadow at reset: default settings, every width and the compare at the minimum
        shadow_cfg = '{MIN_US_RST, MAX_US_RST, TPU_RST};
        for (int m = 0; m < MOTOR_COUNT; m++)
            shadow_width[m] = scale_to_ticks(MIN_US_RST);
        shadow_compare = scale_to_ticks(MIN_US_RST);
        shadow_count   = '0;
        shadow_active  = '0;
        shadow_started = 1'b0;
        shadow_pins    = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part
        foreach (DIR_TABLE[i]) begin
            row = DIR_TABLE[i];
            case (row.kind)
                ROW_CFG: load_settings(row.cfg);
                ROW_RUN: run_to_switch();
                default: send_item(row.op, row.idx, row.us, row.hand, row.res, res);
            endcase
        end

        // Random phases: idle all motors, let the train switch onto the new widths,
        // then mostly ticks and speed requests near the clamp limits.
        for (int ph = 0; ph < 8; ph++) begin
            c = PHASE_CFG[ph];
            if (c.tpu == 0) begin
                c.min_us = US_W'($urandom_range(1, 6));
                c.max_us = US_W'($urandom_range(1, 16));
                c.tpu    = TPU_W'($urandom_range(1, 4));
            end
            load_settings(c);
            gaps_on = (ph % 3 != 1);   // some phases without sender idling
            send_item(OP_IDLE, IDX_W'($urandom), US_W'($urandom), 1'b0, '0, res);
            // a full-scale minimum means a compare far away; don't wait it out
            if (c.min_us != 12'd4095)
                run_to_switch();
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                if (ph == 1 && n == 30)
                    hold_asks++;           // receiver chokes, sender keeps offering
                if (ph == 3 && n == 50)
                    drain_results();       // sender waits for the block to empty
                r = $urandom_range(0, 99);
                if (r < 58)      op = OP_TICK;
                else if (r < 88) op = OP_SPEED;
                else if (r < 94) op = OP_IDLE;
                else             op = OP_SPARE;
                idx = IDX_W'($urandom_range(0, 3));
                k   = $urandom_range(0, 9);
                if (k < 3)      us = US_W'($urandom_range(0, 4095));
                else if (k < 6) us = near_us(c.min_us);
                else if (k < 9) us = near_us(c.max_us);
                else            us = ($urandom_range(0, 1) != 0) ? 12'd4095 : 12'd0;
                send_item(op, idx, us, 1'b0, '0, res);
            end
        end

        // Compare of zero: a zero minimum makes every idle width zero, so after one
        // switch the counter must wrap all the way round before the next.
        load_settings('{12'd0, 12'd4095, 7'd1});
        gaps_on = 1'b0;
        send_item(OP_IDLE, 2'd0, 12'd0, 1'b0, '0, res);
        run_to_switch();
        run_to_switch();
        repeat (8) send_item(OP_TICK, IDX_W'($urandom), US_W'($urandom), 1'b0, '0, res);

        drain_results();
        repeat (10) @(posedge i_clk);   // catch any stray result after the last one owed
        if (faults == 0) begin
            $display("tb_sequential_esc_pulse_generator passed");
        end else begin
            $display("tb_sequential_esc_pulse_generator failed");
        end
        $finish;
    end

endmodule
